// ===== design/bounded_priority_queue_drop_oldest_assert.svh =====
// assertion macros used by the priority queue datapath
`ifndef BOUNDED_PRIORITY_QUEUE_DROP_OLDEST_ASSERT_SVH
`define BOUNDED_PRIORITY_QUEUE_DROP_OLDEST_ASSERT_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define BPQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bpq assertion failed");

// antecedent holds in this cycle, consequent in the next cycle
`define BPQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bpq assertion failed");

`endif

// ===== design/bpq_pkg.sv =====
// shared types, constants and helpers of the bounded priority queue
package bpq_pkg;

    localparam int QUEUE_LIMIT = 48;
    localparam int SLOT_COUNT  = QUEUE_LIMIT + 1;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W       = 6;
    localparam int DROP_W      = 32;
    localparam int IN_DATA_W   = 88;
    localparam int OUT_DATA_W  = 128;
    localparam int OUT_USER_W  = 2;
    localparam int OUT_PAD_W   = OUT_DATA_W - 88 - CNT_W - DROP_W;

    // handle in the lowest bits, then time, then priority
    typedef struct packed {
        logic [7:0]  entry_priority;
        logic [63:0] arrival_time;
        logic [15:0] entry_handle;
    } entry_t;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_code_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD_RD,
        ST_HEAD_CAP,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_SHRINK,
        ST_INS_INIT,
        ST_INS_CHK,
        ST_INS_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic rd_head;
        logic cap_head;
        logic rd_idx;
        logic rd_idx_m1;
        logic shift_wr;
        logic shrink;
        logic idx_init;
        logic move_up;
        logic write_new;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_pop;
        logic count_zero;
        logic count_full;
        logic count_gt1;
        logic shift_more;
        logic idx_zero;
        logic new_before;
        logic out_free;
    } dp_status_t;

    // true if x is served strictly before y
    function automatic logic goes_before(entry_t x, entry_t y);
        logic res;
        if (x.arrival_time != y.arrival_time)
        begin
            res = (x.arrival_time < y.arrival_time);
        end
        else
        begin
            res = (x.entry_priority > y.entry_priority);
        end
        return res;
    endfunction

endpackage

// ===== design/bounded_priority_queue_drop_oldest.sv =====
// top level of the bounded priority queue with drop-oldest overflow
//
// input words on s_*: s_tuser is the command (0 push, 1 pop), s_tdata the
// descriptor. every accepted word yields exactly one output word on m_*:
// m_tuser flags a valid pop or an eviction, m_tdata carries the popped or
// evicted descriptor (zero otherwise), the fill level and the drop count.
// entries are kept sorted in a 49-slot memory, head in slot 0,
// ordered by earliest time, then higher priority, then insertion order.
// the sequencer never reads and writes it in the same cycle. a pop
// captures the head, moves each later entry up one slot and lowers the
// fill level; a pop on an empty queue goes straight to its output word.
// a push to a full queue first evicts the head that way; a push moves
// entries down from the tail until the new entry fits. one word is in work at a time.
// s_tready is high only while idle; the result sits in an output register,
// so the next word is accepted while m_tready is low, and the sequencer
// waits at the end of that next word until the register frees up.
// reset empties the queue and clears the drop counter at once; slot
// contents are left as they are and never read before written.
module bounded_priority_queue_drop_oldest
    import bpq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // entry_handle, arrival_time, entry_priority
    input  logic                  s_tuser,  // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,  // out_handle, out_time, out_priority,
                                            // fill_level, drop_total, zero pad
    output logic [OUT_USER_W-1:0] m_tuser   // pop_valid, evicted
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    bpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    bpq_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// ===== design/bpq_datapath.sv =====
// slot memory, counters, word registers and output register of the queue
`include "bounded_priority_queue_drop_oldest_assert.svh"

module bpq_datapath
    import bpq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status
);

    entry_t                mem [SLOT_COUNT];
    entry_t                rd_data_reg;
    logic                  mem_we;
    logic                  mem_re;
    logic [SLOT_W-1:0]     mem_waddr;
    logic [SLOT_W-1:0]     mem_raddr;
    entry_t                mem_wdata;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SLOT_W-1:0]     idx_reg, idx_next;
    logic [DROP_W-1:0]     drop_reg, drop_next;
    logic                  out_valid_reg, out_valid_next;

    entry_t                new_reg, new_next;
    logic                  is_pop_reg, is_pop_next;
    entry_t                res_reg, res_next;
    logic                  res_pop_reg, res_pop_next;
    logic                  res_evict_reg, res_evict_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [OUT_USER_W-1:0] out_user_reg, out_user_next;

    // memory port selection
    always_comb
    begin
        mem_re    = cmd.rd_head | cmd.rd_idx | cmd.rd_idx_m1;
        mem_raddr = idx_reg;
        if (cmd.rd_head)
        begin
            mem_raddr = '0;
        end
        else if (cmd.rd_idx_m1)
        begin
            mem_raddr = idx_reg - SLOT_W'(1);
        end
        mem_we    = cmd.shift_wr | cmd.move_up | cmd.write_new;
        mem_waddr = cmd.shift_wr ? (idx_reg - SLOT_W'(1)) : idx_reg;
        mem_wdata = cmd.write_new ? new_reg : rd_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.shrink)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        else if (cmd.write_new)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_init)
        begin
            idx_next = SLOT_W'(count_reg);
        end
        else if (cmd.cap_head)
        begin
            idx_next = SLOT_W'(1);
        end
        else if (cmd.shift_wr)
        begin
            idx_next = idx_reg + SLOT_W'(1);
        end
        else if (cmd.move_up)
        begin
            idx_next = idx_reg - SLOT_W'(1);
        end
    end

    always_comb
    begin
        drop_next = drop_reg;
        if (cmd.cap_head && !is_pop_reg)
        begin
            drop_next = drop_reg + DROP_W'(1);
        end
    end

    always_comb
    begin
        new_next       = new_reg;
        is_pop_next    = is_pop_reg;
        res_next       = res_reg;
        res_pop_next   = res_pop_reg;
        res_evict_next = res_evict_reg;
        if (cmd.load_in)
        begin
            new_next       = entry_t'(s_tdata);
            is_pop_next    = (s_tuser == CMD_POP);
            res_next       = '0;
            res_pop_next   = 1'b0;
            res_evict_next = 1'b0;
        end
        else if (cmd.cap_head)
        begin
            res_next       = rd_data_reg;
            res_pop_next   = is_pop_reg;
            res_evict_next = !is_pop_reg;
        end
    end

    // output register frees the core while the word waits
    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {{OUT_PAD_W{1'b0}}, drop_reg, count_reg,
                              res_reg.entry_priority, res_reg.arrival_time,
                              res_reg.entry_handle};
            out_user_next  = {res_evict_reg, res_pop_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            drop_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg       <= new_next;
        is_pop_reg    <= is_pop_next;
        res_reg       <= res_next;
        res_pop_reg   <= res_pop_next;
        res_evict_reg <= res_evict_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
    end

    always_comb
    begin
        status.is_pop     = is_pop_reg;
        status.count_zero = (count_reg == '0);
        status.count_full = (count_reg > CNT_W'(QUEUE_LIMIT));
        status.count_gt1  = (count_reg > CNT_W'(1));
        status.shift_more = ((CNT_W'(idx_reg) + CNT_W'(1)) < count_reg);
        status.idx_zero   = (idx_reg == '0);
        status.new_before = goes_before(new_reg, rd_data_reg);
        status.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `BPQ_ASSERT_IMP(a_evict_only_full, cmd.cap_head && !is_pop_reg, count_reg == CNT_W'(SLOT_COUNT))
    `BPQ_ASSERT_NXT(a_insert_grows, cmd.write_new, count_reg == $past(count_reg) + CNT_W'(1))
    `BPQ_ASSERT_NXT(a_drop_hold, !(cmd.cap_head && !is_pop_reg), drop_reg == $past(drop_reg))
    `BPQ_ASSERT_IMP(a_flags_excl, out_valid_reg, !(out_user_reg[0] && out_user_reg[1]))

endmodule

// ===== design/bpq_ctrl.sv =====
// sequencer that steps the slot memory through pop, evict and insert
module bpq_ctrl
    import bpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic       s_tuser,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser == CMD_POP)
                    begin
                        state_next = status.count_zero ? ST_FINISH : ST_HEAD_RD;
                    end
                    else
                    begin
                        state_next = status.count_full ? ST_HEAD_RD : ST_INS_INIT;
                    end
                end
            end
            ST_HEAD_RD:  state_next = ST_HEAD_CAP;
            ST_HEAD_CAP: state_next = status.count_gt1 ? ST_SHIFT_RD : ST_SHRINK;
            ST_SHIFT_RD: state_next = ST_SHIFT_WR;
            ST_SHIFT_WR: state_next = status.shift_more ? ST_SHIFT_RD : ST_SHRINK;
            ST_SHRINK:   state_next = status.is_pop ? ST_FINISH : ST_INS_INIT;
            ST_INS_INIT: state_next = ST_INS_CHK;
            ST_INS_CHK:  state_next = status.idx_zero ? ST_FINISH : ST_INS_WR;
            ST_INS_WR:   state_next = status.new_before ? ST_INS_CHK : ST_FINISH;
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_HEAD_RD:  cmd.rd_head  = 1'b1;
            ST_HEAD_CAP: cmd.cap_head = 1'b1;
            ST_SHIFT_RD: cmd.rd_idx   = 1'b1;
            ST_SHIFT_WR: cmd.shift_wr = 1'b1;
            ST_SHRINK:   cmd.shrink   = 1'b1;
            ST_INS_INIT: cmd.idx_init = 1'b1;
            ST_INS_CHK:
            begin
                // reached the head: new entry goes to slot zero
                cmd.write_new = status.idx_zero;
                cmd.rd_idx_m1 = !status.idx_zero;
            end
            ST_INS_WR:
            begin
                cmd.move_up   = status.new_before;
                cmd.write_new = !status.new_before;
            end
            ST_FINISH:   cmd.load_out = status.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule
